// ===== hw/rtl/mfr_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mfr_pkg
// Shared types and constants of the mono framebuffer rotator: store and
// counter widths, the item codes, the controller state type and the
// structs that travel between the controller and the top level.
// ============================================================================
package mfr_pkg;

    // Widest source image that is rotated; wider settings saturate here.
    localparam int MAX_WIDTH     = 1024;
    // Longest padded output row in bytes before a fetch reports too wide.
    localparam int MAX_ROW_BYTES = 68;
    // Frame store size in bytes.
    localparam int STORE_DEPTH   = 69632;

    localparam int CFG_W      = 11;                         // register width
    localparam int STORE_AW   = $clog2(STORE_DEPTH);        // load address
    localparam int ROW_W      = $clog2(MAX_WIDTH);          // output row
    localparam int COL_W      = $clog2(MAX_ROW_BYTES);      // byte in row
    localparam int STRIDE_W   = $clog2(MAX_WIDTH / 8) + 1;  // bytes per line
    localparam int RB_W       = CFG_W - 2;                  // padded row bytes
    localparam int PIX_ADDR_W = STRIDE_W + CFG_W;           // byte address
    localparam int X_W        = COL_W + 3;                  // output pixel

    localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'(800);
    localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'(480);

    // Configuration register indexes.
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // Item kinds.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_WRITE,
        S_ADDR,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic                re;
        logic [STORE_AW-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       row_done;
        logic       image_done;
        logic       too_wide;
    } t_result;

endpackage

// ===== hw/rtl/mfr_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mfr_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ============================================================================
module mfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mfr_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mfr_ctrl
// Item sequencer of the rotator: writes load words into the frame store and
// gathers each fetch word from eight store reads, one per cycle.
// ============================================================================
module mfr_ctrl
    import mfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_mode,
    input  logic [16:0]      i_load_addr,
    input  logic [7:0]       i_load_byte,
    input  logic [CFG_W-1:0] i_img_width,
    input  logic [CFG_W-1:0] i_img_height,
    output t_ram_req         o_ram_req,
    input  logic [7:0]       i_ram_rdata,
    input  logic             i_out_free,
    output logic             o_res_push,
    output t_result          o_res
);

    t_state r_state, n_state;

    logic                  r_mode;
    logic [16:0]           r_laddr;
    logic [7:0]            r_lbyte;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      r_col;
    logic [PIX_ADDR_W-1:0] r_img_bytes;
    logic [PIX_ADDR_W-1:0] r_addr;
    logic [ROW_W-1:0]      r_sx;
    logic [X_W-1:0]        r_x;
    logic [3:0]            r_issue;
    logic                  r_pend;
    logic                  r_pend_ok;
    logic [7:0]            r_byte;
    logic                  r_empty;
    logic                  r_wide;

    logic [CFG_W-1:0]      eff_w;
    logic [STRIDE_W-1:0]   stride;
    logic [CFG_W:0]        words;
    logic [RB_W-1:0]       row_bytes;
    logic                  is_empty;
    logic                  is_wide;
    logic                  out_of_range;
    logic [ROW_W-1:0]      sx;
    logic [PIX_ADDR_W-1:0] sy0;
    logic [PIX_ADDR_W-1:0] start_addr;
    logic                  rd_ok;
    logic                  row_end;
    logic                  img_end;
    logic                  load_ok;

    // Image geometry, all from the registers, which the user must hold still during an item (not enforced).
    always_comb begin
        eff_w     = (i_img_width > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : i_img_width;
        stride    = STRIDE_W'(eff_w >> 3);
        words     = ({1'b0, i_img_height} + (CFG_W+1)'(31)) >> 5;
        row_bytes = RB_W'({words, 2'b00});
        is_empty  = (eff_w == '0) || (i_img_height == '0);
        is_wide   = row_bytes > RB_W'(MAX_ROW_BYTES);
        out_of_range = ({1'b0, r_row} >= eff_w) || (RB_W'(r_col) >= row_bytes);
        // Source column of this output row and source row of its first pixel.
        sx        = ROW_W'(eff_w - CFG_W'(1) - CFG_W'(r_row));
        sy0       = PIX_ADDR_W'(i_img_height) - PIX_ADDR_W'(1)
                    - PIX_ADDR_W'({r_col, 3'b000});
        start_addr = PIX_ADDR_W'(sy0 * stride) + PIX_ADDR_W'(sx[ROW_W-1:3]);
        rd_ok     = ({1'b0, r_x} < i_img_height) && (r_addr < r_img_bytes)
                    && (r_addr < PIX_ADDR_W'(STORE_DEPTH));
        row_end   = RB_W'(r_col) == (row_bytes - RB_W'(1));
        img_end   = row_end && ({1'b0, r_row} == (eff_w - CFG_W'(1)));
        load_ok   = (PIX_ADDR_W'(r_laddr) < r_img_bytes)
                    && (PIX_ADDR_W'(r_laddr) < PIX_ADDR_W'(STORE_DEPTH));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                priority if (r_mode == MODE_LOAD) begin
                    n_state = S_WRITE;
                end else if (is_empty || is_wide) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ADDR;
                end
            end
            S_WRITE: n_state = S_IDLE;
            S_ADDR:  n_state = S_READ;
            S_READ: begin
                if (r_issue == 4'd8) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready      = 1'b0;
        o_res_push      = 1'b0;
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_laddr[STORE_AW-1:0];
        o_ram_req.wdata = r_lbyte;
        o_ram_req.re    = 1'b0;
        o_ram_req.raddr = r_addr[STORE_AW-1:0];
        o_res.out_byte   = r_byte;
        o_res.row_done   = row_end;
        o_res.image_done = img_end;
        o_res.too_wide   = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_WRITE: o_ram_req.we = load_ok;
            S_READ:  o_ram_req.re = (r_issue != 4'd8) && rd_ok;
            S_DONE: begin
                o_res_push = i_out_free;
                priority if (r_empty) begin
                    o_res.out_byte   = 8'h00;
                    o_res.row_done   = 1'b1;
                    o_res.image_done = 1'b1;
                end else if (r_wide) begin
                    o_res.out_byte   = 8'h00;
                    o_res.row_done   = 1'b0;
                    o_res.image_done = 1'b0;
                    o_res.too_wide   = 1'b1;
                end else begin
                    o_res.too_wide   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_PREP) && (r_mode == MODE_FETCH) && !is_empty
                && !is_wide && out_of_range) begin
                r_row <= '0;
                r_col <= '0;
            end
            if (r_state == S_READ) begin
                r_pend <= (r_issue != 4'd8);
            end else begin
                r_pend <= 1'b0;
            end
            if ((r_state == S_DONE) && i_out_free) begin
                priority if (r_empty) begin
                    r_row <= '0;
                    r_col <= '0;
                end else if (r_wide) begin
                    r_row <= r_row;
                end else if (row_end) begin
                    r_col <= '0;
                    r_row <= img_end ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_mode  <= i_mode;
            r_laddr <= i_load_addr;
            r_lbyte <= i_load_byte;
        end
        if (r_state == S_PREP) begin
            r_img_bytes <= PIX_ADDR_W'(stride) * PIX_ADDR_W'(i_img_height);
            r_empty     <= is_empty;
            r_wide      <= !is_empty && is_wide;
        end
        if (r_state == S_ADDR) begin
            r_sx    <= sx;
            r_addr  <= start_addr;
            r_x     <= {r_col, 3'b000};
            r_issue <= '0;
            r_byte  <= '0;
        end
        if (r_state == S_READ) begin
            if (r_issue != 4'd8) begin
                r_pend_ok <= rd_ok;
                r_addr    <= r_addr - PIX_ADDR_W'(stride);
                r_x       <= r_x + X_W'(1);
                r_issue   <= r_issue + 4'd1;
            end
            if (r_pend) begin
                r_byte <= {r_byte[6:0], r_pend_ok & i_ram_rdata[~r_sx[2:0]]};
            end
        end
    end

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> i_out_free)
        else $error("result pushed into a full output register");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_PREP))
        else $error("accepted word did not start processing");

    a_counters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && !r_empty && !r_wide)
        |=> ((RB_W'(r_col) < row_bytes) && ({1'b0, r_row} < eff_w)))
        else $error("output position left the image after a fetch");

    a_eight_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !r_empty && !r_wide) |-> (r_issue == 4'd8))
        else $error("fetch finished without eight store reads");

endmodule

// ===== hw/rtl/mono_framebuffer_rotate_ccw.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mono_framebuffer_rotate_ccw
// Loads a 1 bpp framebuffer into a frame store and hands out the image
// rotated 90 degrees counter-clockwise, one byte per fetch word.
// ============================================================================
//
//   Channel | Handshake                   | Payload
//   --------+-----------------------------+--------------------------------
//   input   | i_in_valid / o_in_ready     | i_mode, i_load_addr, i_load_byte
//   output  | o_out_valid / i_out_ready   | o_out_byte, o_row_done,
//           |                             | o_image_done, o_too_wide
//   config  | i_cfg_we (no wait)          | i_cfg_addr, i_cfg_wdata
//
// A load word passes through accept, address check and store write. A fetch
// word passes through accept, geometry, start address, eight frame store
// reads through its single read port plus the last read return, and a final
// step that hands the result over; an empty or too-wide image skips the reads.
// Reset sets the width to 800 and the height to 480 and the output position
// to the first byte; the frame store is not cleared.
// A new word is accepted while a result still waits in the output register;
// a fetch whose result is ready holds in its last step until that register
// is free.
//
module mono_framebuffer_rotate_ccw
    import mfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input words.
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_mode,
    input  logic [16:0]      i_load_addr,
    input  logic [7:0]       i_load_byte,
    // Result words.
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_row_done,
    output logic             o_image_done,
    output logic             o_too_wide,
    // Configuration writes.
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    logic [CFG_W-1:0] r_img_width;
    logic [CFG_W-1:0] r_img_height;
    logic             r_out_valid;
    t_result          r_out;

    t_ram_req         ram_req;
    logic [7:0]       ram_rdata;
    logic             out_free;
    logic             res_push;
    t_result          res;

    // Configuration registers. The user must write them only while the block is
    // idle (the block does not enforce it), so the sequencer reads them directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= RST_WIDTH;
            r_img_height <= RST_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_IDX_WIDTH:  r_img_width  <= i_cfg_wdata;
                CFG_IDX_HEIGHT: r_img_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // The frame store holds one source byte per entry, row-major.
    mfr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // The sequencer walks one source column upward, eight pixels per word.
    mfr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_load_addr  (i_load_addr),
        .i_load_byte  (i_load_byte),
        .i_img_width  (r_img_width),
        .i_img_height (r_img_height),
        .o_ram_req    (ram_req),
        .i_ram_rdata  (ram_rdata),
        .i_out_free   (out_free),
        .o_res_push   (res_push),
        .o_res        (res)
    );

    // Output register: it frees itself in the same cycle it is taken.
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out.out_byte;
    assign o_row_done   = r_out.row_done;
    assign o_image_done = r_out.image_done;
    assign o_too_wide   = r_out.too_wide;

endmodule
